// ===== design/u8s_pkg.sv =====
package u8s_pkg;

    localparam logic [7:0] REPL_BYTE = 8'h3F;

    localparam int unsigned RES_DEPTH = 4;

    typedef logic [7:0] byte_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic pop;
    } u8s_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic has_results;
        logic at_final;
    } u8s_sts_t;

endpackage

// ===== design/u8s_datapath.sv =====
module u8s_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  u8s_pkg::u8s_cmd_t cmd,
    output u8s_pkg::u8s_sts_t sts,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    // sequence state
    u8s_pkg::byte_t held_reg [3];
    u8s_pkg::byte_t held_next [3];
    logic [2:0]     seq_len_reg;
    logic [2:0]     seq_len_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic [20:0]    cp_reg;
    logic [20:0]    cp_next;

    // result buffer
    u8s_pkg::byte_t res_reg [u8s_pkg::RES_DEPTH];
    u8s_pkg::byte_t res_next [u8s_pkg::RES_DEPTH];
    logic [1:0]     final_idx_reg;
    logic [1:0]     rd_ptr_reg;
    logic           res_last_reg;

    logic [2:0]     n_res;
    logic           seq_open;
    logic           is_cont;
    logic           lead2;
    logic           lead3;
    logic           lead4;
    logic           fresh_hold;
    logic [7:0]     fresh_byte;
    logic [2:0]     fresh_len;
    logic [20:0]    fresh_cp;
    logic [20:0]    cp_shift;
    logic           complete;
    logic           cp_ok;

    assign seq_open = (seq_len_reg != 3'd0) && (cnt_reg != 2'd0);
    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign lead2    = (in_byte[7:5] == 3'b110);
    assign lead3    = (in_byte[7:4] == 4'b1110);
    assign lead4    = (in_byte[7:3] == 5'b11110);

    assign fresh_hold = (lead2 || lead3 || lead4) && !in_last;
    assign fresh_byte = in_byte[7] ? u8s_pkg::REPL_BYTE : in_byte;

    always_comb
    begin
        fresh_len = 3'd4;
        fresh_cp  = {18'd0, in_byte[2:0]};
        if (lead2)
        begin
            fresh_len = 3'd2;
            fresh_cp  = {16'd0, in_byte[4:0]};
        end
        else if (lead3)
        begin
            fresh_len = 3'd3;
            fresh_cp  = {17'd0, in_byte[3:0]};
        end
    end

    assign cp_shift = {cp_reg[14:0], in_byte[5:0]};
    assign complete = ({1'b0, cnt_reg} + 3'd1) >= seq_len_reg;

    always_comb
    begin
        cp_ok = 1'b1;
        if (seq_len_reg == 3'd2 && cp_shift < 21'h80)
            cp_ok = 1'b0;
        if (seq_len_reg == 3'd3 && cp_shift < 21'h800)
            cp_ok = 1'b0;
        if (seq_len_reg == 3'd4 && cp_shift < 21'h10000)
            cp_ok = 1'b0;
        if (cp_shift >= 21'hD800 && cp_shift <= 21'hDFFF)
            cp_ok = 1'b0;
        if (cp_shift > 21'h10FFFF)
            cp_ok = 1'b0;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            held_next[k] = held_reg[k];
        for (int k = 0; k < u8s_pkg::RES_DEPTH; k++)
            res_next[k] = u8s_pkg::REPL_BYTE;
        seq_len_next = 3'd0;
        cnt_next     = 2'd0;
        cp_next      = 21'd0;
        n_res        = 3'd0;

        if (seq_open && is_cont)
        begin
            if (complete)
            begin
                for (int k = 0; k < 3; k++)
                    if (k < cnt_reg && cp_ok)
                        res_next[k] = held_reg[k];
                res_next[cnt_reg] = cp_ok ? in_byte : u8s_pkg::REPL_BYTE;
                n_res = {1'b0, cnt_reg} + 3'd1;
            end
            else if (in_last)
            begin
                n_res = {1'b0, cnt_reg} + 3'd1;
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                    if (cnt_reg == k[1:0])
                        held_next[k] = in_byte;
                seq_len_next = seq_len_reg;
                cnt_next     = cnt_reg + 2'd1;
                cp_next      = cp_shift;
            end
        end
        else
        begin
            // cut short: one replacement per held byte, then restart on this byte
            if (seq_open)
                n_res = {1'b0, cnt_reg};
            if (fresh_hold)
            begin
                held_next[0] = in_byte;
                seq_len_next = fresh_len;
                cnt_next     = 2'd1;
                cp_next      = fresh_cp;
            end
            else
            begin
                res_next[n_res[1:0]] = fresh_byte;
                n_res = n_res + 3'd1;
            end
        end
    end

    assign sts.has_results = (n_res != 3'd0);
    assign sts.at_final    = (rd_ptr_reg == final_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= 3'd0;
            cnt_reg     <= 2'd0;
            cp_reg      <= 21'd0;
            rd_ptr_reg  <= 2'd0;
        end
        else if (cmd.load)
        begin
            seq_len_reg <= seq_len_next;
            cnt_reg     <= cnt_next;
            cp_reg      <= cp_next;
            rd_ptr_reg  <= 2'd0;
        end
        else if (cmd.pop)
        begin
            rd_ptr_reg <= rd_ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 3; k++)
                held_reg[k] <= held_next[k];
            for (int k = 0; k < u8s_pkg::RES_DEPTH; k++)
                res_reg[k] <= res_next[k];
            final_idx_reg <= n_res[1:0] - 2'd1;
            res_last_reg  <= in_last;
        end
    end

    assign out_byte = res_reg[rd_ptr_reg];
    assign out_last = res_last_reg && (rd_ptr_reg == final_idx_reg);

endmodule

// ===== design/u8s_ctrl.sv =====
module u8s_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output u8s_pkg::u8s_cmd_t cmd,
    input  u8s_pkg::u8s_sts_t sts
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;

    assign cmd.load  = in_valid && !in_stall_reg;
    assign cmd.pop   = out_valid_reg && !out_stall;
    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load && sts.has_results)
                    begin
                        state_reg     <= ST_DRAIN;
                        in_stall_reg  <= 1'b1;
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (cmd.pop && sts.at_final)
                    begin
                        state_reg     <= ST_IDLE;
                        in_stall_reg  <= 1'b0;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    in_stall_reg  <= 1'b0;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== design/utf8_sanitizer.sv =====
// UTF-8 sanitizer: passes ASCII and well-formed multibyte sequences unchanged and
// replaces every byte of a bad or cut-off sequence with '?' (0x3F); a byte that
// breaks an open sequence is then decoded afresh. The results of a request (none
// while a sequence is being collected, up to four otherwise) are then sent one per
// cycle while out_stall is low from a four-entry result buffer; in_stall stays high
// until the last of them leaves, and the next request is taken the cycle after it.
// out_last marks the final result of a request that carried in_last.
module utf8_sanitizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    u8s_pkg::u8s_cmd_t cmd;
    u8s_pkg::u8s_sts_t sts;

    u8s_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    u8s_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .out_byte (out_byte),
        .out_last (out_last)
    );

endmodule

// ===== design/u8s_checker.sv =====
module u8s_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled result changed");

    // no new request while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while results pending");

    // results only follow an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result without request");

    // the end-of-string result closes the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_last |=> !out_valid && !in_stall)
        else $error("results continue after last");

endmodule

bind utf8_sanitizer u8s_checker u_u8s_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
);

// ===== tb/utf8_sanitizer_tb.sv =====
module utf8_sanitizer_tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } san_out_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [7:0] want_data;
        logic       want_last;
    } dir_row_t;

    localparam logic TYPED      = 1'b1;
    localparam logic PRED       = 1'b0;
    localparam int   DIR_ROWS   = 27;
    localparam int   RAND_ITEMS = 392;
    localparam int   HOLD_AT    = DIR_ROWS + 100;
    localparam int   DRAIN_AT   = DIR_ROWS + 250;
    localparam int   LONG_HOLD  = 300;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       out_last;

    // expectation attached to the request on the bus, if typed in
    logic       cur_typed;
    logic [7:0] cur_want_data;
    logic       cur_want_last;

    san_out_t   sanitized_q [$];
    dir_row_t   dir_rows [DIR_ROWS];
    int         err_cnt;
    int         sent_cnt;
    int         burst_left;
    logic       hold_off_req;

    // decoder state of the predictor
    logic [7:0]  seq_bytes [3];
    logic [2:0]  seq_len;
    logic [1:0]  seq_cnt;
    logic [20:0] seq_cp;
    logic [7:0]  step_out [4];
    int          step_n;

    utf8_sanitizer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    function void add_expected(input san_out_t res);
        sanitized_q.insert(sanitized_q.size(), res);
    endfunction

    function void emit_byte(input logic [7:0] b);
        step_out[step_n] = b;
        step_n++;
    endfunction

    function void drop_seq();
        seq_len = 3'd0;
        seq_cnt = 2'd0;
        seq_cp  = 21'd0;
    endfunction

    function void start_byte(input logic [7:0] b, input logic l);
        logic [2:0]  need;
        logic [20:0] init;
        need = 3'd0;
        init = 21'd0;
        if (b < 8'h80)
            emit_byte(b);
        else
        begin
            if (b[7:5] == 3'b110)
            begin
                need = 3'd2;
                init = {16'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                need = 3'd3;
                init = {17'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                need = 3'd4;
                init = {18'd0, b[2:0]};
            end
            // bad lead, or a lead that the end of string cuts off
            if (need == 3'd0 || l)
                emit_byte(u8s_pkg::REPL_BYTE);
            else
            begin
                seq_bytes[0] = b;
                seq_cnt      = 2'd1;
                seq_len      = need;
                seq_cp       = init;
            end
        end
    endfunction

    function logic cp_legal(input logic [2:0] len, input logic [20:0] cp);
        cp_legal = !((len == 3'd2 && cp < 21'h80) ||
                     (len == 3'd3 && cp < 21'h800) ||
                     (len == 3'd4 && cp < 21'h10000) ||
                     (cp >= 21'hD800 && cp <= 21'hDFFF) ||
                     (cp > 21'h10FFFF));
    endfunction

    function void sanitize_byte(input logic [7:0] b, input logic l);
        logic ok;
        int   k;
        step_n = 0;
        if (seq_len == 3'd0 || seq_cnt == 2'd0)
        begin
            drop_seq();
            start_byte(b, l);
        end
        else if (b[7:6] == 2'b10)
        begin
            seq_cp = {seq_cp[14:0], b[5:0]};
            if (seq_cnt + 3'd1 >= seq_len)
            begin
                ok = cp_legal(seq_len, seq_cp);
                for (k = 0; k < seq_cnt; k++)
                    emit_byte(ok ? seq_bytes[k] : u8s_pkg::REPL_BYTE);
                emit_byte(ok ? b : u8s_pkg::REPL_BYTE);
                drop_seq();
            end
            else if (l)
            begin
                for (k = 0; k <= seq_cnt; k++)
                    emit_byte(u8s_pkg::REPL_BYTE);
                drop_seq();
            end
            else
            begin
                seq_bytes[seq_cnt] = b;
                seq_cnt = seq_cnt + 2'd1;
            end
        end
        else
        begin
            // held bytes are lost, the breaking byte starts over
            for (k = 0; k < seq_cnt; k++)
                emit_byte(u8s_pkg::REPL_BYTE);
            drop_seq();
            start_byte(b, l);
        end
    endfunction

    always @(posedge clk)
    begin
        san_out_t want;
        int       k;
        if (rst_n)
        begin
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                sanitize_byte(in_byte, in_last);
                if (cur_typed)
                begin
                    want.data = cur_want_data;
                    want.last = cur_want_last;
                    add_expected(want);
                end
                else
                begin
                    for (k = 0; k < step_n; k++)
                    begin
                        want.data = step_out[k];
                        want.last = in_last && (k == step_n - 1);
                        add_expected(want);
                    end
                end
            end
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (sanitized_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %h out_last %b", out_byte, out_last);
                    err_cnt++;
                end
                else
                begin
                    want = sanitized_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %h, actual %h", want.data, out_byte);
                        err_cnt++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %b, actual %b", want.last, out_last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // receiver: runs of ready and stalled cycles, plus one long hold on request
    initial
    begin
        int   run_left;
        int   r;
        logic stall_val;
        logic hold_seen;
        out_stall = 1'b0;
        run_left  = 0;
        stall_val = 1'b0;
        hold_seen = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_seen)
            begin
                hold_seen = 1'b1;
                stall_val = 1'b1;
                run_left  = LONG_HOLD;
            end
            else if (run_left <= 0)
            begin
                r = $urandom_range(0, 19);
                if (r < 10)
                begin
                    stall_val = 1'b0;
                    run_left  = $urandom_range(1, 40);
                end
                else if (r < 17)
                begin
                    stall_val = 1'b1;
                    run_left  = $urandom_range(1, 3);
                end
                else if (r < 19)
                begin
                    stall_val = 1'b0;
                    run_left  = 1;
                end
                else
                begin
                    stall_val = 1'b1;
                    run_left  = $urandom_range(10, 40);
                end
            end
            out_stall <= stall_val;
            run_left--;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input logic [7:0] want_data, input logic want_last);
        int gap;
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end
            else if (r < 60)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 30);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        in_last       <= l;
        cur_typed     <= typed;
        cur_want_data <= want_data;
        cur_want_last <= want_last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sent_cnt++;
    endtask

    task automatic send_rand(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 23) == 0, PRED, 8'h00, 1'b0);
    endtask

    initial
    begin
        int         r;
        int         len;
        int         i;
        logic [7:0] lead;
        logic [7:0] c;
        logic       hold_done;
        logic       drain_done;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        in_last       = 1'b0;
        cur_typed     = 1'b0;
        cur_want_data = 8'h00;
        cur_want_last = 1'b0;
        hold_off_req  = 1'b0;
        err_cnt       = 0;
        sent_cnt      = 0;
        burst_left    = 0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        seq_bytes     = '{8'h00, 8'h00, 8'h00};
        drop_seq();
        dir_rows = '{
            '{8'h00, 1'b0, TYPED, 8'h00, 1'b0},
            '{8'h7F, 1'b1, TYPED, 8'h7F, 1'b1},
            '{8'h80, 1'b0, TYPED, u8s_pkg::REPL_BYTE, 1'b0},     // stray continuation
            '{8'hFF, 1'b0, TYPED, u8s_pkg::REPL_BYTE, 1'b0},     // bad lead
            '{8'hC3, 1'b1, TYPED, u8s_pkg::REPL_BYTE, 1'b1},     // lead cut by end of string
            '{8'hC3, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hA9, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hE2, 1'b0, PRED, 8'h00, 1'b0},
            '{8'h82, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hAC, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hF0, 1'b0, PRED, 8'h00, 1'b0},
            '{8'h9F, 1'b0, PRED, 8'h00, 1'b0},
            '{8'h98, 1'b0, PRED, 8'h00, 1'b0},
            '{8'h80, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hC0, 1'b0, PRED, 8'h00, 1'b0},          // overlong
            '{8'h80, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hED, 1'b0, PRED, 8'h00, 1'b0},          // surrogate
            '{8'hA0, 1'b0, PRED, 8'h00, 1'b0},
            '{8'h80, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hF4, 1'b0, PRED, 8'h00, 1'b0},          // above the unicode range
            '{8'h90, 1'b0, PRED, 8'h00, 1'b0},
            '{8'h80, 1'b0, PRED, 8'h00, 1'b0},
            '{8'h80, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hE2, 1'b0, PRED, 8'h00, 1'b0},          // broken by plain ascii
            '{8'h41, 1'b0, PRED, 8'h00, 1'b0},
            '{8'hE2, 1'b0, PRED, 8'h00, 1'b0},          // broken by end of string
            '{8'h82, 1'b1, PRED, 8'h00, 1'b0}
        };
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[k])
            send_byte(dir_rows[k].data, dir_rows[k].last, dir_rows[k].typed,
                      dir_rows[k].want_data, dir_rows[k].want_last);

        while (sent_cnt < DIR_ROWS + RAND_ITEMS)
        begin
            if (!hold_done && sent_cnt >= HOLD_AT)
            begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && sent_cnt >= DRAIN_AT)
            begin
                // take the last request off the bus before waiting
                @(negedge clk);
                in_valid <= 1'b0;
                while (sanitized_q.size() != 0)
                    @(posedge clk);
                drain_done = 1'b1;
            end
            r = $urandom_range(0, 9);
            if (r < 3)
                send_rand(8'($urandom_range(0, 127)));
            else if (r < 8)
            begin
                // mostly well-formed multibyte, now and then a broken one
                len = $urandom_range(2, 4);
                if (len == 2)
                    lead = 8'hC0 | 8'($urandom_range(0, 31));
                else if (len == 3)
                    lead = 8'hE0 | 8'($urandom_range(0, 15));
                else if ($urandom_range(0, 9) < 8)
                    lead = 8'hF0 + 8'($urandom_range(0, 4));
                else
                    lead = 8'hF5 + 8'($urandom_range(0, 2));
                send_rand(lead);
                for (i = 1; i < len; i++)
                begin
                    c = 8'h80 | 8'($urandom_range(0, 63));
                    if ($urandom_range(0, 11) == 0)
                        c = 8'($urandom_range(0, 255));
                    send_rand(c);
                end
            end
            else if (r < 9)
                send_rand(8'h80 | 8'($urandom_range(0, 63)));
            else
                send_rand(8'($urandom_range(0, 255)));
        end
        // close the string so nothing is left held
        send_byte(8'($urandom_range(0, 127)), 1'b1, PRED, 8'h00, 1'b0);
        @(negedge clk);
        in_valid <= 1'b0;

        while (sanitized_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
